// ----- design/sic_pkg.sv -----
// Shared types and constants for the segment intersection core.
`default_nettype none
package sic_pkg;

	localparam int unsigned CoordW = 16;
	localparam int unsigned DiffW  = 17;
	localparam int unsigned ProdW  = 34;
	localparam int unsigned DetW   = 35;
	localparam int unsigned PointW = 24;

	typedef enum logic [1:0] {
		ST_NONE     = 2'd0,
		ST_HIT      = 2'd1,
		ST_PARALLEL = 2'd2
	} status_t;

	// Classified request handed from the front end to the interpolation back end.
	typedef struct packed {
		status_t                   status;
		logic signed [CoordW-1:0]  x1;
		logic signed [CoordW-1:0]  y1;
		logic signed [DiffW-1:0]   dx;
		logic signed [DiffW-1:0]   dy;
		logic signed [DetW-1:0]    na;
		logic signed [DetW-1:0]    det;
	} mid_item_t;

endpackage
`default_nettype wire

// ----- design/sic_fifo.sv -----
// Small register queue between the front and back ends.
`default_nettype none
module sic_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      rdata,
	output logic                  empty
);
	localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CntW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0]  count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == CntW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule
`default_nettype wire

// ----- design/sic_front.sv -----
// Front end: differences, cross products and classification of each segment pair.
`default_nettype none
module sic_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	output logic                     full,
	input  wire logic signed [15:0]  p1_x,
	input  wire logic signed [15:0]  p1_y,
	input  wire logic signed [15:0]  p2_x,
	input  wire logic signed [15:0]  p2_y,
	input  wire logic signed [15:0]  p3_x,
	input  wire logic signed [15:0]  p3_y,
	input  wire logic signed [15:0]  p4_x,
	input  wire logic signed [15:0]  p4_y,
	output logic                     item_valid,
	input  wire logic                item_ready,
	output sic_pkg::mid_item_t       item
);
	logic v_s1, v_s2, v_s3, v_s4;
	logic adv;

	// Stage 1 differences
	logic signed [15:0] x1_s1, y1_s1;
	logic signed [16:0] dx_s1, dy_s1, a_s1, b_s1, c_s1, e_s1, f_s1, g_s1, h_s1;
	// Stage 2 products
	logic signed [15:0] x1_s2, y1_s2;
	logic signed [16:0] dx_s2, dy_s2;
	logic signed [33:0] ab_s2, ce_s2, fg_s2, ah_s2, bg_s2, dxh_s2;
	// Stage 3 determinant and numerators
	logic signed [15:0] x1_s3, y1_s3;
	logic signed [16:0] dx_s3, dy_s3;
	logic signed [34:0] det_s3, na_s3, nb_s3;

	logic signed [35:0] dn, nan, nbn;
	sic_pkg::status_t   status;

	assign adv        = !v_s4 || item_ready;
	assign full       = !adv;
	assign item_valid = v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= push;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Normalise the signs so that the parameter tests become plain range checks.
	always_comb begin
		dn  = det_s3[34] ? -36'(det_s3) : 36'(det_s3);
		nan = det_s3[34] ? -36'(na_s3) : 36'(na_s3);
		nbn = det_s3[34] ? -36'(nb_s3) : 36'(nb_s3);
		if (det_s3 == '0) begin
			status = sic_pkg::ST_PARALLEL;
		end else if (!nan[35] && (nan <= dn) && !nbn[35] && (nbn <= dn)) begin
			status = sic_pkg::ST_HIT;
		end else begin
			status = sic_pkg::ST_NONE;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x1_s1 <= p1_x;
			y1_s1 <= p1_y;
			dx_s1 <= {p2_x[15], p2_x} - {p1_x[15], p1_x};
			dy_s1 <= {p2_y[15], p2_y} - {p1_y[15], p1_y};
			a_s1  <= {p4_x[15], p4_x} - {p3_x[15], p3_x};
			b_s1  <= {p1_y[15], p1_y} - {p2_y[15], p2_y};
			c_s1  <= {p1_x[15], p1_x} - {p2_x[15], p2_x};
			e_s1  <= {p4_y[15], p4_y} - {p3_y[15], p3_y};
			f_s1  <= {p3_y[15], p3_y} - {p4_y[15], p4_y};
			g_s1  <= {p1_x[15], p1_x} - {p3_x[15], p3_x};
			h_s1  <= {p1_y[15], p1_y} - {p3_y[15], p3_y};

			x1_s2  <= x1_s1;
			y1_s2  <= y1_s1;
			dx_s2  <= dx_s1;
			dy_s2  <= dy_s1;
			ab_s2  <= 34'(a_s1) * 34'(b_s1);
			ce_s2  <= 34'(c_s1) * 34'(e_s1);
			fg_s2  <= 34'(f_s1) * 34'(g_s1);
			ah_s2  <= 34'(a_s1) * 34'(h_s1);
			bg_s2  <= 34'(b_s1) * 34'(g_s1);
			dxh_s2 <= 34'(dx_s1) * 34'(h_s1);

			x1_s3  <= x1_s2;
			y1_s3  <= y1_s2;
			dx_s3  <= dx_s2;
			dy_s3  <= dy_s2;
			det_s3 <= 35'(ab_s2) - 35'(ce_s2);
			na_s3  <= 35'(fg_s2) + 35'(ah_s2);
			nb_s3  <= 35'(bg_s2) + 35'(dxh_s2);

			item.status <= status;
			item.x1     <= x1_s3;
			item.y1     <= y1_s3;
			item.dx     <= dx_s3;
			item.dy     <= dy_s3;
			item.na     <= na_s3;
			item.det    <= det_s3;
		end
	end

endmodule
`default_nettype wire

// ----- design/sic_back.sv -----
// Back end: exact interpolation and a pipelined restoring divider per coordinate.
`default_nettype none
module sic_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               item_valid,
	output logic                    item_pop,
	input  wire sic_pkg::mid_item_t item,
	output logic                    empty,
	input  wire logic               pop,
	output logic [1:0]              hit_status,
	output logic signed [23:0]      cross_x,
	output logic signed [23:0]      cross_y
);
	localparam int unsigned QBits = 24;

	logic adv;
	logic v_s1, v_s2, out_v_q;

	sic_pkg::status_t   st_s1, st_s2;
	logic signed [34:0] det_s1, det_s2;
	logic signed [52:0] mx_s1, nx_s1, my_s1, ny_s1;
	logic signed [53:0] sx_s2, sy_s2;

	// Divider stage arrays; index 0 is the operand stage.
	logic               dv_s   [QBits+1];
	sic_pkg::status_t   dst_s  [QBits+1];
	logic               sgx_s  [QBits+1];
	logic               sgy_s  [QBits+1];
	logic [34:0]        dm_s   [QBits+1];
	logic [35:0]        rx_s   [QBits+1];
	logic [35:0]        ry_s   [QBits+1];
	logic [QBits-1:0]   lx_s   [QBits+1];
	logic [QBits-1:0]   ly_s   [QBits+1];
	logic [QBits-1:0]   qx_s   [QBits+1];
	logic [QBits-1:0]   qy_s   [QBits+1];

	logic [53:0] magx, magy;

	assign adv      = !out_v_q || pop;
	assign empty    = !out_v_q;
	assign item_pop = adv && item_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			out_v_q <= 1'b0;
			for (int i = 0; i <= QBits; i++) begin
				dv_s[i] <= 1'b0;
			end
		end else if (adv) begin
			v_s1    <= item_valid;
			v_s2    <= v_s1;
			dv_s[0] <= v_s2;
			for (int i = 1; i <= QBits; i++) begin
				dv_s[i] <= dv_s[i-1];
			end
			out_v_q <= dv_s[QBits];
		end
	end

	assign magx = sx_s2[53] ? 54'(-sx_s2) : 54'(sx_s2);
	assign magy = sy_s2[53] ? 54'(-sy_s2) : 54'(sy_s2);

	always_ff @(posedge clk) begin
		if (adv) begin
			st_s1  <= item.status;
			det_s1 <= item.det;
			mx_s1  <= 53'(item.x1) * 53'(item.det);
			nx_s1  <= 53'(item.dx) * 53'(item.na);
			my_s1  <= 53'(item.y1) * 53'(item.det);
			ny_s1  <= 53'(item.dy) * 53'(item.na);

			st_s2  <= st_s1;
			det_s2 <= det_s1;
			sx_s2  <= 54'(mx_s1) + 54'(nx_s1);
			sy_s2  <= 54'(my_s1) + 54'(ny_s1);

			// The dividend is the magnitude scaled by 256; its top part seeds the remainder.
			dst_s[0] <= st_s2;
			sgx_s[0] <= sx_s2[53] ^ det_s2[34];
			sgy_s[0] <= sy_s2[53] ^ det_s2[34];
			dm_s[0]  <= det_s2[34] ? 35'(-det_s2) : 35'(det_s2);
			rx_s[0]  <= magx[51:16];
			ry_s[0]  <= magy[51:16];
			lx_s[0]  <= {magx[15:0], 8'h00};
			ly_s[0]  <= {magy[15:0], 8'h00};
			qx_s[0]  <= '0;
			qy_s[0]  <= '0;
		end
	end

	for (genvar k = 0; k < QBits; k++) begin : g_div
		logic [36:0] trial_x, trial_y, diff_x, diff_y;
		logic        ge_x, ge_y;

		always_comb begin
			trial_x = {rx_s[k], lx_s[k][QBits-1]};
			trial_y = {ry_s[k], ly_s[k][QBits-1]};
			diff_x  = trial_x - {2'b00, dm_s[k]};
			diff_y  = trial_y - {2'b00, dm_s[k]};
			ge_x    = (trial_x >= {2'b00, dm_s[k]});
			ge_y    = (trial_y >= {2'b00, dm_s[k]});
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dst_s[k+1] <= dst_s[k];
				sgx_s[k+1] <= sgx_s[k];
				sgy_s[k+1] <= sgy_s[k];
				dm_s[k+1]  <= dm_s[k];
				rx_s[k+1]  <= ge_x ? diff_x[35:0] : trial_x[35:0];
				ry_s[k+1]  <= ge_y ? diff_y[35:0] : trial_y[35:0];
				lx_s[k+1]  <= {lx_s[k][QBits-2:0], 1'b0};
				ly_s[k+1]  <= {ly_s[k][QBits-2:0], 1'b0};
				qx_s[k+1]  <= {qx_s[k][QBits-2:0], ge_x};
				qy_s[k+1]  <= {qy_s[k][QBits-2:0], ge_y};
			end
		end
	end

	// The point is only reported for a hit; truncation toward zero follows from
	// dividing magnitudes and restoring the sign afterwards.
	always_ff @(posedge clk) begin
		if (adv) begin
			hit_status <= dst_s[QBits];
			if (dst_s[QBits] == sic_pkg::ST_HIT) begin
				cross_x <= sgx_s[QBits] ? -qx_s[QBits] : qx_s[QBits];
				cross_y <= sgy_s[QBits] ? -qy_s[QBits] : qy_s[QBits];
			end else begin
				cross_x <= '0;
				cross_y <= '0;
			end
		end
	end

endmodule
`default_nettype wire

// ----- design/segment_intersection_core.sv -----
// Pipeline: 4 front stages, the queue, then 28 back stages.
// Throughput: one segment pair per cycle while nothing stalls, set by the fully pipelined
// multipliers and the 24-stage restoring divider, one quotient bit per stage per coordinate.
// The front and back ends stall independently; the queue between them holds MID_DEPTH requests.
// Reset (arst_n low, asynchronous) empties every stage and the queue; no other state is kept.
`default_nettype none
module segment_intersection_core #(
	parameter int unsigned MID_DEPTH = 4
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire logic signed [15:0] p1_x,
	input  wire logic signed [15:0] p1_y,
	input  wire logic signed [15:0] p2_x,
	input  wire logic signed [15:0] p2_y,
	input  wire logic signed [15:0] p3_x,
	input  wire logic signed [15:0] p3_y,
	input  wire logic signed [15:0] p4_x,
	input  wire logic signed [15:0] p4_y,
	output logic                    empty,
	input  wire logic               pop,
	output logic [1:0]              hit_status,
	output logic signed [23:0]      cross_x,
	output logic signed [23:0]      cross_y
);
	localparam int unsigned ItemW = $bits(sic_pkg::mid_item_t);

	logic               f_valid, mid_full, mid_empty, mid_pop;
	sic_pkg::mid_item_t f_item, m_item;

	sic_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.p1_x       (p1_x),
		.p1_y       (p1_y),
		.p2_x       (p2_x),
		.p2_y       (p2_y),
		.p3_x       (p3_x),
		.p3_y       (p3_y),
		.p4_x       (p4_x),
		.p4_y       (p4_y),
		.item_valid (f_valid),
		.item_ready (!mid_full),
		.item       (f_item)
	);

	sic_fifo #(
		.WIDTH (ItemW),
		.DEPTH (MID_DEPTH)
	) u_mid (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_valid),
		.wdata  (f_item),
		.full   (mid_full),
		.pop    (mid_pop),
		.rdata  (m_item),
		.empty  (mid_empty)
	);

	sic_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (!mid_empty),
		.item_pop   (mid_pop),
		.item       (m_item),
		.empty      (empty),
		.pop        (pop),
		.hit_status (hit_status),
		.cross_x    (cross_x),
		.cross_y    (cross_y)
	);

endmodule
`default_nettype wire
